// ===== src/countdown_timer_bank_assert.svh =====
// ----------------------------------------------------------------------------
// countdown_timer_bank assertion macros
// Shorthand for the concurrent checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef COUNTDOWN_TIMER_BANK_ASSERT_SVH
`define COUNTDOWN_TIMER_BANK_ASSERT_SVH

// Same-cycle implication, off during reset.
`define CTB_CHECK_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("countdown_timer_bank: check failed");

// Next-cycle implication, off during reset.
`define CTB_CHECK_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("countdown_timer_bank: check failed");

`endif

// ===== src/ctb_pkg.sv =====
// ----------------------------------------------------------------------------
// ctb_pkg
// Shared constants, codes and structs of the countdown timer bank.
// ----------------------------------------------------------------------------
package ctb_pkg;

    localparam int SLOTS       = 5;
    localparam int COUNT_BITS  = 24;
    localparam int SLOT_IN_W   = 3;
    localparam int SLOT_SPAN   = 1 << SLOT_IN_W;
    localparam int MASK_W      = 5;
    localparam int DUR_IN_W    = 24;
    localparam int REM_OUT_W   = 24;
    localparam int PCT_W       = 7;
    localparam int PCT_SCALE   = 100;
    localparam int THR_W       = 16;
    localparam int CMP_W       = (COUNT_BITS > THR_W) ? COUNT_BITS : THR_W;
    localparam int NUM_W       = COUNT_BITS + PCT_W;
    localparam int DIV_CNT_W   = $clog2(PCT_W);
    localparam int CFG_IDX_W   = 1;

    localparam logic [THR_W-1:0] WARN_RESET   = THR_W'(60);
    localparam logic [THR_W-1:0] URGENT_RESET = THR_W'(30);

    typedef enum logic [1:0] {
        ACT_TICK  = 2'd0,
        ACT_ADD   = 2'd1,
        ACT_CLICK = 2'd2,
        ACT_CLEAR = 2'd3
    } t_action;

    typedef enum logic [2:0] {
        ST_TICK      = 3'd0,
        ST_ADDED     = 3'd1,
        ST_FULL      = 3'd2,
        ST_EMPTY     = 3'd3,
        ST_DISMISSED = 3'd4,
        ST_TOGGLED   = 3'd5,
        ST_CLEARED   = 3'd6
    } t_status;

    typedef enum logic [1:0] {
        URG_NORMAL  = 2'd0,
        URG_WARNING = 2'd1,
        URG_URGENT  = 2'd2,
        URG_EXPIRED = 2'd3
    } t_urgency;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WARN   = 1'b0,
        CFG_URGENT = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        logic                  en;
        t_action               action;
        logic [COUNT_BITS-1:0] dur;
    } t_cell_cmd;

    typedef struct packed {
        logic                  active;
        logic                  running;
        logic                  expired;
        logic [COUNT_BITS-1:0] duration;
        logic [COUNT_BITS-1:0] remaining;
    } t_cell_view;

endpackage

// ===== src/countdown_timer_bank.sv =====
// ----------------------------------------------------------------------------
// countdown_timer_bank
// Bank of countdown timers driven by tick, add, click and clear beats.
// ----------------------------------------------------------------------------
// Each input beat runs from acceptance to a result beat through S_APPLY
// (apply the action in the row of slot cells, pick the reported slot),
// S_LOAD (capture the slot views), S_PREP (form the percent numerator),
// S_DIV (the one-bit-per-cycle percent divider) and S_DONE (load the output
// register once it is free). A new beat is taken once the previous one
// leaves the pipeline, even while its result still waits in the output
// register. Threshold writes land at once and are meant for an idle bank.
module countdown_timer_bank import ctb_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [1:0]           i_action,
    input  logic [SLOT_IN_W-1:0] i_slot,
    input  logic [DUR_IN_W-1:0]  i_duration_sec,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [2:0]           o_status,
    output logic [SLOT_IN_W-1:0] o_target_slot,
    output logic [MASK_W-1:0]    o_active_mask,
    output logic [MASK_W-1:0]    o_running_mask,
    output logic [MASK_W-1:0]    o_expired_mask,
    output logic [MASK_W-1:0]    o_newly_expired_mask,
    output logic                 o_alarm,
    output logic [REM_OUT_W-1:0] o_remaining_out,
    output logic [PCT_W-1:0]     o_progress_pct,
    output logic [1:0]           o_urgency,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_addr,
    input  logic [THR_W-1:0]     i_cfg_wdata
);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_APPLY = 6'b000010,
        S_LOAD  = 6'b000100,
        S_PREP  = 6'b001000,
        S_DIV   = 6'b010000,
        S_DONE  = 6'b100000
    } t_state;

    t_state r_state, n_state;

    logic [THR_W-1:0]      r_warn;
    logic [THR_W-1:0]      r_urgent;
    t_action               r_action;
    logic [SLOT_IN_W-1:0]  r_slot;
    logic [COUNT_BITS-1:0] r_dur;

    t_status               r_status;
    logic [SLOT_IN_W-1:0]  r_target;
    logic [SLOTS-1:0]      r_pick;
    logic [SLOTS-1:0]      r_newly;
    logic [SLOTS-1:0]      r_act_m;
    logic [SLOTS-1:0]      r_run_m;
    logic [SLOTS-1:0]      r_exp_m;
    logic [COUNT_BITS-1:0] r_rem_t;
    logic [COUNT_BITS-1:0] r_dur_t;
    logic                  r_act_t;
    logic                  r_exp_t;
    logic                  r_ok;
    t_urgency              r_urg;

    logic                  r_out_valid;
    logic [2:0]            r_out_status;
    logic [SLOT_IN_W-1:0]  r_out_target;
    logic [MASK_W-1:0]     r_out_act;
    logic [MASK_W-1:0]     r_out_run;
    logic [MASK_W-1:0]     r_out_exp;
    logic [MASK_W-1:0]     r_out_newly;
    logic                  r_out_alarm;
    logic [REM_OUT_W-1:0]  r_out_rem;
    logic [PCT_W-1:0]      r_out_pct;
    logic [1:0]            r_out_urg;

    t_cell_cmd                        cmd;
    t_cell_view [SLOTS-1:0]           view;
    logic [SLOTS-1:0]                 sel;
    logic [SLOTS-1:0]                 claim;
    logic [SLOTS-1:0]                 expiring;
    logic [SLOTS:0]                   taken;
    logic [SLOTS:0][SLOT_IN_W-1:0]    idx_chain;

    logic                  in_fire;
    logic                  out_load;
    logic                  sel_active;
    logic                  sel_expired;
    logic [SLOTS-1:0]      act_v;
    logic [SLOTS-1:0]      run_v;
    logic [SLOTS-1:0]      exp_v;
    logic [COUNT_BITS-1:0] pick_rem;
    logic [COUNT_BITS-1:0] pick_dur;
    logic                  pick_act;
    logic                  pick_exp;
    t_status               status_now;
    logic                  pct_ok;
    logic [NUM_W-1:0]      pct_num;
    t_urgency              urg_now;
    logic                  div_done;
    logic [PCT_W-1:0]      div_quot;

    assign in_fire    = i_in_valid && o_in_ready;
    assign o_in_ready = (r_state == S_IDLE);
    assign out_load   = (r_state == S_DONE) && (!r_out_valid || i_out_ready);

    assign cmd = '{en: (r_state == S_APPLY), action: r_action, dur: r_dur};

    // row of slot cells; the add claim ripples from slot 0 upward
    assign taken[0]     = 1'b0;
    assign idx_chain[0] = '0;

    for (genvar g = 0; g < SLOTS; g++) begin : g_cell
        assign sel[g] = (g < SLOT_SPAN) && (r_slot == SLOT_IN_W'(g));

        ctb_cell u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_cmd       (cmd),
            .i_sel       (sel[g]),
            .i_own_idx   (SLOT_IN_W'(g)),
            .i_taken     (taken[g]),
            .i_idx_chain (idx_chain[g]),
            .o_taken     (taken[g+1]),
            .o_idx_chain (idx_chain[g+1]),
            .o_claim     (claim[g]),
            .o_expiring  (expiring[g]),
            .o_view      (view[g])
        );
    end

    always_comb begin
        sel_active  = 1'b0;
        sel_expired = 1'b0;
        pick_rem    = '0;
        pick_dur    = '0;
        pick_act    = 1'b0;
        pick_exp    = 1'b0;
        for (int i = 0; i < SLOTS; i++) begin
            act_v[i]    = view[i].active;
            run_v[i]    = view[i].running;
            exp_v[i]    = view[i].expired;
            sel_active  = sel_active  | (sel[i] & view[i].active);
            sel_expired = sel_expired | (sel[i] & view[i].expired);
            pick_rem    = pick_rem | (view[i].remaining & {COUNT_BITS{r_pick[i]}});
            pick_dur    = pick_dur | (view[i].duration & {COUNT_BITS{r_pick[i]}});
            pick_act    = pick_act | (view[i].active & r_pick[i]);
            pick_exp    = pick_exp | (view[i].expired & r_pick[i]);
        end
    end

    always_comb begin
        unique case (r_action)
            ACT_TICK:  status_now = ST_TICK;
            ACT_ADD:   status_now = taken[SLOTS] ? ST_ADDED : ST_FULL;
            ACT_CLICK: begin
                if (!sel_active) begin
                    status_now = ST_EMPTY;
                end else if (sel_expired) begin
                    status_now = ST_DISMISSED;
                end else begin
                    status_now = ST_TOGGLED;
                end
            end
            ACT_CLEAR: status_now = ST_CLEARED;
            default:   status_now = ST_TICK;
        endcase
    end

    assign pct_ok  = r_act_t && (r_dur_t != '0) && (r_rem_t <= r_dur_t);
    assign pct_num = pct_ok ? (NUM_W'(r_dur_t - r_rem_t) * NUM_W'(PCT_SCALE)) : '0;

    always_comb begin
        priority if (!r_act_t) begin
            urg_now = URG_NORMAL;
        end else if (r_exp_t) begin
            urg_now = URG_EXPIRED;
        end else if (CMP_W'(r_rem_t) <= CMP_W'(r_urgent)) begin
            urg_now = URG_URGENT;
        end else if (CMP_W'(r_rem_t) <= CMP_W'(r_warn)) begin
            urg_now = URG_WARNING;
        end else begin
            urg_now = URG_NORMAL;
        end
    end

    ctb_pct_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == S_PREP),
        .i_num   (pct_num),
        .i_den   (r_dur_t),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (in_fire) n_state = S_APPLY;
            S_APPLY: n_state = S_LOAD;
            S_LOAD:  n_state = S_PREP;
            S_PREP:  n_state = S_DIV;
            S_DIV:   if (div_done) n_state = S_DONE;
            S_DONE:  if (out_load) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_warn      <= WARN_RESET;
            r_urgent    <= URGENT_RESET;
        end else begin
            r_state <= n_state;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                unique case (t_cfg_idx'(i_cfg_addr))
                    CFG_WARN:   r_warn   <= i_cfg_wdata;
                    CFG_URGENT: r_urgent <= i_cfg_wdata;
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_action <= t_action'(i_action);
            r_slot   <= i_slot;
            r_dur    <= COUNT_BITS'(i_duration_sec);
        end
        // status and report slot come from the state before the action
        if (r_state == S_APPLY) begin
            r_status <= status_now;
            r_newly  <= expiring;
            if (r_action == ACT_ADD && taken[SLOTS]) begin
                r_target <= idx_chain[SLOTS];
                r_pick   <= claim;
            end else begin
                r_target <= r_slot;
                r_pick   <= sel;
            end
        end
        if (r_state == S_LOAD) begin
            r_act_m <= act_v;
            r_run_m <= run_v;
            r_exp_m <= exp_v;
            r_rem_t <= pick_rem;
            r_dur_t <= pick_dur;
            r_act_t <= pick_act;
            r_exp_t <= pick_exp;
        end
        if (r_state == S_PREP) begin
            r_ok  <= pct_ok;
            r_urg <= urg_now;
        end
        if (out_load) begin
            r_out_status <= r_status;
            r_out_target <= r_target;
            r_out_act    <= MASK_W'(r_act_m);
            r_out_run    <= MASK_W'(r_run_m);
            r_out_exp    <= MASK_W'(r_exp_m);
            r_out_newly  <= MASK_W'(r_newly);
            r_out_alarm  <= (r_exp_m != '0);
            r_out_rem    <= REM_OUT_W'(r_rem_t);
            r_out_pct    <= r_ok ? div_quot : '0;
            r_out_urg    <= r_urg;
        end
    end

    assign o_out_valid          = r_out_valid;
    assign o_status             = r_out_status;
    assign o_target_slot        = r_out_target;
    assign o_active_mask        = r_out_act;
    assign o_running_mask       = r_out_run;
    assign o_expired_mask       = r_out_exp;
    assign o_newly_expired_mask = r_out_newly;
    assign o_alarm              = r_out_alarm;
    assign o_remaining_out      = r_out_rem;
    assign o_progress_pct       = r_out_pct;
    assign o_urgency            = r_out_urg;

`include "countdown_timer_bank_assert.svh"

    `CTB_CHECK_NEXT(a_accept_drops_ready, in_fire, !o_in_ready)
    `CTB_CHECK_SAME(a_newly_in_expired, r_out_valid, (r_out_newly & ~r_out_exp) == '0)
    `CTB_CHECK_SAME(a_run_exp_disjoint, r_out_valid, (r_out_run & r_out_exp) == '0)
    `CTB_CHECK_SAME(a_expired_raises_alarm, r_out_valid && r_out_urg == URG_EXPIRED, r_out_alarm)

endmodule

// ===== src/ctb_cell.sv =====
// ----------------------------------------------------------------------------
// ctb_cell
// One timer slot. Passes the add claim down the row to its neighbor.
// ----------------------------------------------------------------------------
module ctb_cell import ctb_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_cell_cmd            i_cmd,
    input  logic                 i_sel,
    input  logic [SLOT_IN_W-1:0] i_own_idx,
    input  logic                 i_taken,
    input  logic [SLOT_IN_W-1:0] i_idx_chain,
    output logic                 o_taken,
    output logic [SLOT_IN_W-1:0] o_idx_chain,
    output logic                 o_claim,
    output logic                 o_expiring,
    output t_cell_view           o_view
);

    logic                  r_active,    n_active;
    logic                  r_running,   n_running;
    logic                  r_expired,   n_expired;
    logic [COUNT_BITS-1:0] r_duration,  n_duration;
    logic [COUNT_BITS-1:0] r_remaining, n_remaining;

    logic free;
    logic live;

    assign free        = !r_active || r_expired;
    assign live        = r_active && r_running && !r_expired;
    assign o_taken     = i_taken || free;
    assign o_idx_chain = (free && !i_taken) ? i_own_idx : i_idx_chain;
    assign o_claim     = (i_cmd.action == ACT_ADD) && free && !i_taken;
    assign o_expiring  = (i_cmd.action == ACT_TICK) && live
                         && (r_remaining <= COUNT_BITS'(1));

    assign o_view = '{active: r_active, running: r_running, expired: r_expired,
                      duration: r_duration, remaining: r_remaining};

    always_comb begin
        n_active    = r_active;
        n_running   = r_running;
        n_expired   = r_expired;
        n_duration  = r_duration;
        n_remaining = r_remaining;
        if (i_cmd.en) begin
            unique case (i_cmd.action)
                ACT_TICK: begin
                    if (live) begin
                        if (r_remaining != '0) begin
                            n_remaining = r_remaining - COUNT_BITS'(1);
                        end
                        if (o_expiring) begin
                            n_running = 1'b0;
                            n_expired = 1'b1;
                        end
                    end
                end
                ACT_ADD: begin
                    if (o_claim) begin
                        n_active    = 1'b1;
                        n_running   = 1'b1;
                        n_expired   = 1'b0;
                        n_duration  = i_cmd.dur;
                        n_remaining = i_cmd.dur;
                    end
                end
                ACT_CLICK: begin
                    if (i_sel && r_active) begin
                        if (r_expired) begin
                            n_active    = 1'b0;
                            n_running   = 1'b0;
                            n_expired   = 1'b0;
                            n_duration  = '0;
                            n_remaining = '0;
                        end else begin
                            n_running = !r_running;
                            // reload a stopped-at-zero slot
                            if (r_remaining == '0) begin
                                n_remaining = r_duration;
                            end
                        end
                    end
                end
                ACT_CLEAR: begin
                    if (i_sel) begin
                        n_active    = 1'b0;
                        n_running   = 1'b0;
                        n_expired   = 1'b0;
                        n_duration  = '0;
                        n_remaining = '0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active    <= 1'b0;
            r_running   <= 1'b0;
            r_expired   <= 1'b0;
            r_duration  <= '0;
            r_remaining <= '0;
        end else begin
            r_active    <= n_active;
            r_running   <= n_running;
            r_expired   <= n_expired;
            r_duration  <= n_duration;
            r_remaining <= n_remaining;
        end
    end

endmodule

// ===== src/ctb_pct_div.sv =====
// ----------------------------------------------------------------------------
// ctb_pct_div
// Restoring divider for the percent figure, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ctb_pct_div import ctb_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [COUNT_BITS-1:0] i_den,
    output logic             o_done,
    output logic [PCT_W-1:0] o_quot
);

    logic                 r_busy;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [NUM_W-1:0]     r_rem;
    logic [NUM_W-1:0]     r_dsh;
    logic [PCT_W-1:0]     r_q;
    logic                 ge;

    // quotient never reaches 2**PCT_W, so the top trial shift is PCT_W-1
    assign ge     = r_rem >= r_dsh;
    assign o_done = r_busy && (r_cnt == '0);
    assign o_quot = r_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_start) begin
            r_busy <= 1'b1;
        end else if (o_done) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_cnt <= DIV_CNT_W'(PCT_W - 1);
            r_rem <= i_num;
            r_dsh <= NUM_W'(i_den) << (PCT_W - 1);
            r_q   <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt - DIV_CNT_W'(1);
            r_rem <= ge ? (r_rem - r_dsh) : r_rem;
            r_dsh <= r_dsh >> 1;
            r_q   <= {r_q[PCT_W-2:0], ge};
        end
    end

endmodule
